>>> src/i2cms_pkg.sv
// Shared types and constants of the I2C master bit sequencer.
package i2cms_pkg;

    // Command codes carried by req_type, plus the idle marker.
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_RESTART = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_IDLE    = 3'd7;

    // Delay lengths in bus timing units.
    localparam logic [5:0] DLY_3  = 6'd3;
    localparam logic [5:0] DLY_7  = 6'd7;
    localparam logic [5:0] DLY_10 = 6'd10;
    localparam logic [5:0] DLY_20 = 6'd20;
    localparam logic [5:0] DLY_25 = 6'd25;
    localparam logic [5:0] DLY_50 = 6'd50;

    // Timing register width, reset value, and default prescaler width.
    localparam int          TPU_W             = 16;
    localparam logic [15:0] TPU_RESET         = 16'd1;
    localparam int          PRESCALE_BITS_DEF = 16;

    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH = 2;

    // One classified tick as it travels from the front to the back.
    typedef struct packed {
        logic       cmd_valid;
        logic       cmd_known;
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_tick;

endpackage

>>> src/i2c_master_bit_sequencer_core.sv
// Top level of the I2C master bit sequencer: front queue and bus sequencer.
// Each input beat is one bus timing tick and yields exactly one result beat giving the
// SCL/SDA drive levels, busy, and on the completing tick the done pulse with the
// acknowledge flag or the read byte. One tick is taken every clock cycle while the
// queue has room; a tick's result passes the queue and the output register, and either
// side may stall independently because a two-entry queue separates the front from the
// sequencer and the sequencer drives a registered output stage. The sequencer is
// the single stage that sets the rate: it consumes one queued tick per cycle whenever
// its output register is empty or being taken. Bus timing is counted in ticks, so a
// delay of n units lasts n times ticks_per_unit ticks (zero counts as one); the timing
// register should only be written while no sequence is running.
module i2c_master_bit_sequencer_core #(
    parameter int PRESCALE_BITS = i2cms_pkg::PRESCALE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd_valid,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_send_ack,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_ack_received,
    output logic [7:0]  o_rx_byte,
    output logic        o_cmd_rejected
);
    import i2cms_pkg::*;

    logic  q_valid;
    t_tick q_tick;
    logic  q_pop;

    // Front end: accept and classify tick beats.
    i2cms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd_valid (i_cmd_valid),
        .i_req_type  (i_req_type),
        .i_tx_byte   (i_tx_byte),
        .i_send_ack  (i_send_ack),
        .i_sda_in    (i_sda_in),
        .o_q_valid   (q_valid),
        .o_q_tick    (q_tick),
        .i_q_pop     (q_pop)
    );

    // Back end: bus sequencer and result register.
    i2cms_back #(
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_q_tick       (q_tick),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_scl_level    (o_scl_level),
        .o_sda_level    (o_sda_level),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_ack_received (o_ack_received),
        .o_rx_byte      (o_rx_byte),
        .o_cmd_rejected (o_cmd_rejected)
    );

endmodule

>>> src/i2cms_front.sv
// Front end: accepts tick beats, classifies the command, and queues them.
module i2cms_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cmd_valid,
    input  logic [2:0]       i_req_type,
    input  logic [7:0]       i_tx_byte,
    input  logic             i_send_ack,
    input  logic             i_sda_in,
    output logic             o_q_valid,
    output i2cms_pkg::t_tick o_q_tick,
    input  logic             i_q_pop
);
    import i2cms_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_tick              r_q [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    t_tick              new_tick;

    // Classify the incoming beat: only codes start through read can begin a sequence.
    always_comb begin
        new_tick.cmd_valid = i_cmd_valid;
        new_tick.cmd_known = (i_req_type <= CMD_READ);
        new_tick.req_type  = i_req_type;
        new_tick.tx_byte   = i_tx_byte;
        new_tick.send_ack  = i_send_ack;
        new_tick.sda_in    = i_sda_in;
    end

    assign o_in_ready = (r_count != CNT_W'(Q_DEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_tick   = r_q[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_tick;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> src/i2cms_back.sv
// Back end: steps the bus sequence one tick per beat and registers the result.
module i2cms_back #(
    parameter int PRESCALE_BITS = i2cms_pkg::PRESCALE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_q_valid,
    input  i2cms_pkg::t_tick i_q_tick,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_scl_level,
    output logic             o_sda_level,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic             o_ack_received,
    output logic [7:0]       o_rx_byte,
    output logic             o_cmd_rejected
);
    import i2cms_pkg::*;

    localparam logic [PRESCALE_BITS-1:0] PRESC_ONE = PRESCALE_BITS'(1);

    // Phase codes of the sequencer.
    localparam logic [3:0] PH_S0 = 4'd0;
    localparam logic [3:0] PH_S1 = 4'd1;
    localparam logic [3:0] PH_S2 = 4'd2;
    localparam logic [3:0] PH_S3 = 4'd3;
    localparam logic [3:0] PH_S4 = 4'd4;
    localparam logic [3:0] PH_S5 = 4'd5;
    localparam logic [3:0] PH_S6 = 4'd6;

    logic [TPU_W-1:0]         r_tpu;
    logic [2:0]               r_active, n_active;
    logic [3:0]               r_phase, n_phase;
    logic [2:0]               r_bit_index, n_bit_index;
    logic [5:0]               r_unit_wait, n_unit_wait;
    logic [PRESCALE_BITS-1:0] r_presc, n_presc;
    logic [7:0]               r_shift, n_shift;
    logic                     r_scl, n_scl;
    logic                     r_sda, n_sda;
    logic                     r_ack, n_ack;

    logic                     r_out_valid;
    logic                     r_o_scl, r_o_sda, r_o_busy, r_o_done, r_o_ack, r_o_rej;
    logic [7:0]               r_o_rx;

    logic [31:0]              tpu_wide;
    logic [PRESCALE_BITS-1:0] period_raw;
    logic [PRESCALE_BITS-1:0] period;
    logic                     busy_before;
    logic                     run_step;
    logic                     done;
    logic [2:0]               done_cmd;
    logic                     ack_out;
    logic [7:0]               rx_out;

    // Unit period: low prescaler bits of the register, zero taken as one.
    assign tpu_wide   = 32'(r_tpu);
    assign period_raw = tpu_wide[PRESCALE_BITS-1:0];
    assign period     = (period_raw == '0) ? PRESC_ONE : period_raw;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_out_ready);

    // One tick of the sequencer: count down the delay, then run the phase actions.
    always_comb begin
        busy_before = (r_active != CMD_IDLE);
        n_active    = r_active;
        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_unit_wait = r_unit_wait;
        n_presc     = r_presc;
        n_shift     = r_shift;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack       = r_ack;
        run_step    = 1'b0;
        done        = 1'b0;
        done_cmd    = CMD_IDLE;
        ack_out     = 1'b0;
        rx_out      = 8'd0;

        if (busy_before) begin
            if (r_presc > PRESC_ONE) begin
                n_presc = r_presc - PRESC_ONE;
            end else begin
                n_presc = period;
                if (r_unit_wait > 6'd1) begin
                    n_unit_wait = r_unit_wait - 6'd1;
                end else begin
                    n_unit_wait = 6'd0;
                    run_step    = 1'b1;
                end
            end
        end else if (i_q_tick.cmd_valid && i_q_tick.cmd_known) begin
            n_active    = i_q_tick.req_type;
            n_phase     = PH_S0;
            n_bit_index = 3'd0;
            if (i_q_tick.req_type == CMD_WRITE) begin
                n_shift = i_q_tick.tx_byte;
                n_ack   = 1'b0;
            end
            if (i_q_tick.req_type == CMD_READ) begin
                n_shift = 8'd0;
                n_ack   = i_q_tick.send_ack;
            end
            run_step = 1'b1;
        end

        if (run_step) begin
            n_presc = period;
            unique case (n_active)
                CMD_START: begin
                    unique case (n_phase)
                        PH_S0: begin
                            n_scl = 1'b1; n_sda = 1'b1;
                            n_unit_wait = DLY_10; n_phase = PH_S1;
                        end
                        PH_S1: begin
                            n_sda = 1'b0;
                            n_unit_wait = DLY_10; n_phase = PH_S2;
                        end
                        default: begin
                            n_scl = 1'b0; done = 1'b1;
                        end
                    endcase
                end
                CMD_RESTART: begin
                    unique case (n_phase)
                        PH_S0: begin
                            n_unit_wait = DLY_10; n_phase = PH_S1;
                        end
                        PH_S1: begin
                            n_scl = 1'b1; n_sda = 1'b1;
                            n_unit_wait = DLY_10; n_phase = PH_S2;
                        end
                        PH_S2: begin
                            n_sda = 1'b0;
                            n_unit_wait = DLY_10; n_phase = PH_S3;
                        end
                        default: begin
                            n_scl = 1'b0; done = 1'b1;
                        end
                    endcase
                end
                CMD_STOP: begin
                    unique case (n_phase)
                        PH_S0: begin
                            n_sda = 1'b0; n_scl = 1'b0;
                            n_unit_wait = DLY_10; n_phase = PH_S1;
                        end
                        PH_S1: begin
                            n_scl = 1'b1;
                            n_unit_wait = DLY_10; n_phase = PH_S2;
                        end
                        default: begin
                            n_sda = 1'b1; done = 1'b1;
                        end
                    endcase
                end
                CMD_WRITE: begin
                    unique case (n_phase)
                        PH_S0: begin
                            n_sda = n_shift[7];
                            n_unit_wait = DLY_10; n_phase = PH_S1;
                        end
                        PH_S1: begin
                            n_scl = 1'b1;
                            n_unit_wait = DLY_10; n_phase = PH_S2;
                        end
                        PH_S2: begin
                            n_scl = 1'b0;
                            if (n_bit_index == 3'd7) begin
                                n_sda = 1'b1;
                                n_unit_wait = DLY_20; n_phase = PH_S3;
                            end else begin
                                n_bit_index = n_bit_index + 3'd1;
                                n_sda       = n_shift[6];
                                n_shift     = {n_shift[6:0], 1'b0};
                                n_unit_wait = DLY_10; n_phase = PH_S1;
                            end
                        end
                        PH_S3: begin
                            n_scl = 1'b1;
                            n_unit_wait = DLY_25; n_phase = PH_S4;
                        end
                        PH_S4: begin
                            n_ack = !i_q_tick.sda_in;
                            n_unit_wait = DLY_25; n_phase = PH_S5;
                        end
                        default: begin
                            n_scl = 1'b0; done = 1'b1;
                        end
                    endcase
                end
                CMD_READ: begin
                    unique case (n_phase)
                        PH_S0: begin
                            n_sda = 1'b1;
                            n_unit_wait = DLY_10; n_phase = PH_S1;
                        end
                        PH_S1: begin
                            n_scl = 1'b1;
                            n_unit_wait = DLY_7; n_phase = PH_S2;
                        end
                        PH_S2: begin
                            n_shift = {n_shift[6:0], i_q_tick.sda_in};
                            n_unit_wait = DLY_3; n_phase = PH_S3;
                        end
                        PH_S3: begin
                            n_scl = 1'b0;
                            n_unit_wait = DLY_10;
                            if (n_bit_index == 3'd7) begin
                                n_phase = PH_S4;
                            end else begin
                                n_bit_index = n_bit_index + 3'd1;
                                n_phase     = PH_S1;
                            end
                        end
                        PH_S4: begin
                            n_sda = !n_ack;
                            n_unit_wait = DLY_10; n_phase = PH_S5;
                        end
                        PH_S5: begin
                            n_scl = 1'b1;
                            n_unit_wait = DLY_50; n_phase = PH_S6;
                        end
                        default: begin
                            n_scl = 1'b0; done = 1'b1;
                        end
                    endcase
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end

        // A finished sequence returns the sequencer to idle.
        if (done) begin
            done_cmd    = n_active;
            n_active    = CMD_IDLE;
            n_phase     = PH_S0;
            n_unit_wait = 6'd0;
            n_presc     = '0;
        end

        ack_out = done && (done_cmd == CMD_WRITE) && n_ack;
        rx_out  = (done && (done_cmd == CMD_READ)) ? n_shift : 8'd0;
    end

    // Timing register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu <= TPU_RESET;
        end else if (i_cfg_we) begin
            r_tpu <= i_cfg_data;
        end
    end

    // Sequencer state advances once per consumed beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= CMD_IDLE;
            r_phase     <= PH_S0;
            r_bit_index <= 3'd0;
            r_unit_wait <= 6'd0;
            r_presc     <= '0;
            r_shift     <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack       <= 1'b0;
        end else if (o_q_pop) begin
            r_active    <= n_active;
            r_phase     <= n_phase;
            r_bit_index <= n_bit_index;
            r_unit_wait <= n_unit_wait;
            r_presc     <= n_presc;
            r_shift     <= n_shift;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_ack       <= n_ack;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_o_scl  <= n_scl;
            r_o_sda  <= n_sda;
            r_o_busy <= (n_active != CMD_IDLE);
            r_o_done <= done;
            r_o_ack  <= ack_out;
            r_o_rx   <= rx_out;
            r_o_rej  <= i_q_tick.cmd_valid && busy_before;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_level    = r_o_scl;
    assign o_sda_level    = r_o_sda;
    assign o_busy_res     = r_o_busy;
    assign o_done_res     = r_o_done;
    assign o_ack_received = r_o_ack;
    assign o_rx_byte      = r_o_rx;
    assign o_cmd_rejected = r_o_rej;

`ifndef SYNTHESIS
    // A completed sequence never reports busy on the same beat.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done reported together with busy");

    // The acknowledge result only appears with done.
    a_ack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ack_received) |-> o_done_res)
        else $error("ack result without done");

    // The read byte only appears with done.
    a_rx_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_rx_byte != 8'd0)) |-> o_done_res)
        else $error("read byte without done");

    // An idle sequencer holds no pending delay and sits at the first phase.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active == CMD_IDLE) |-> ((r_unit_wait == 6'd0) && (r_phase == PH_S0)))
        else $error("idle sequencer with leftover delay or phase");
`endif

endmodule

>>> test/tb_i2c_master_bit_sequencer_core.sv
// Self-checking testbench for the I2C master bit sequencer core.
`timescale 1ns / 100ps

module tb_i2c_master_bit_sequencer_core;
    import i2cms_pkg::*;

    localparam int IDLE_PCT  = 34;
    localparam int SETTLE    = 6;
    localparam int STALL_MAX = 1000;

    // How the sampled SDA level is chosen while a sequence runs.
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    // Request codes that no command uses.
    localparam logic [2:0] CMD_UNK_A = 3'd5;
    localparam logic [2:0] CMD_UNK_B = 3'd6;

    // One input tick and one result beat as seen on the ports.
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_drv_tick;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic       ack;
        logic [7:0] rx;
        logic       rejected;
    } t_levels;

    // Tracks the bus sequencer tick by tick and holds the pin levels still due.
    class i2c_bus_tracker;
        logic [15:0] tpu;
        logic [2:0]  cmd_now;
        logic [3:0]  step;
        logic [3:0]  bit_cnt;
        logic [5:0]  units_left;
        logic [15:0] tick_left;
        logic [7:0]  shreg;
        logic        scl_drv;
        logic        sda_drv;
        logic        ack_bit;
        t_levels     levels_due[$];
        int unsigned faults;
        int unsigned beats_seen;

        function new();
            tpu        = TPU_RESET;
            cmd_now    = CMD_IDLE;
            step       = '0;
            bit_cnt    = '0;
            units_left = '0;
            tick_left  = '0;
            shreg      = '0;
            scl_drv    = 1'b1;
            sda_drv    = 1'b1;
            ack_bit    = 1'b0;
            faults     = 0;
            beats_seen = 0;
        endfunction

        function void write_tpu(logic [15:0] v);
            tpu = v;
        endfunction

        function bit busy();
            return cmd_now != CMD_IDLE;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        function logic [15:0] unit_ticks();
            return (tpu == '0) ? 16'd1 : tpu;
        endfunction

        function void arm(logic [5:0] units, logic [3:0] nxt);
            units_left = units;
            tick_left  = unit_ticks();
            step       = nxt;
        endfunction

        // True when the next tick performs the closing action of the sequence.
        function bit finishing_next();
            logic [3:0] last;
            case (cmd_now)
                CMD_START, CMD_STOP: last = 4'd2;
                CMD_RESTART:         last = 4'd3;
                CMD_WRITE:           last = 4'd5;
                CMD_READ:            last = 4'd6;
                default:             return 1'b0;
            endcase
            return (step == last) && (tick_left <= 16'd1) && (units_left <= 6'd1);
        endfunction

        // Carry out the actions due in the current step; 1 when the sequence ends.
        function bit perform(logic sda_in);
            case (cmd_now)
                CMD_START: begin
                    if (step == 4'd0) begin
                        scl_drv = 1'b1;
                        sda_drv = 1'b1;
                        arm(DLY_10, 4'd1);
                    end else if (step == 4'd1) begin
                        sda_drv = 1'b0;
                        arm(DLY_10, 4'd2);
                    end else begin
                        scl_drv = 1'b0;
                        return 1'b1;
                    end
                end
                CMD_RESTART: begin
                    if (step == 4'd0) begin
                        arm(DLY_10, 4'd1);
                    end else if (step == 4'd1) begin
                        scl_drv = 1'b1;
                        sda_drv = 1'b1;
                        arm(DLY_10, 4'd2);
                    end else if (step == 4'd2) begin
                        sda_drv = 1'b0;
                        arm(DLY_10, 4'd3);
                    end else begin
                        scl_drv = 1'b0;
                        return 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (step == 4'd0) begin
                        sda_drv = 1'b0;
                        scl_drv = 1'b0;
                        arm(DLY_10, 4'd1);
                    end else if (step == 4'd1) begin
                        scl_drv = 1'b1;
                        arm(DLY_10, 4'd2);
                    end else begin
                        sda_drv = 1'b1;
                        return 1'b1;
                    end
                end
                CMD_WRITE: begin
                    case (step)
                        4'd0: begin
                            sda_drv = shreg[7];
                            arm(DLY_10, 4'd1);
                        end
                        4'd1: begin
                            scl_drv = 1'b1;
                            arm(DLY_10, 4'd2);
                        end
                        4'd2: begin
                            scl_drv = 1'b0;
                            if (bit_cnt >= 4'd7) begin
                                sda_drv = 1'b1;
                                arm(DLY_20, 4'd3);
                            end else begin
                                bit_cnt = bit_cnt + 4'd1;
                                shreg   = shreg << 1;
                                sda_drv = shreg[7];
                                arm(DLY_10, 4'd1);
                            end
                        end
                        4'd3: begin
                            scl_drv = 1'b1;
                            arm(DLY_25, 4'd4);
                        end
                        4'd4: begin
                            ack_bit = ~sda_in;
                            arm(DLY_25, 4'd5);
                        end
                        default: begin
                            scl_drv = 1'b0;
                            return 1'b1;
                        end
                    endcase
                end
                CMD_READ: begin
                    case (step)
                        4'd0: begin
                            sda_drv = 1'b1;
                            arm(DLY_10, 4'd1);
                        end
                        4'd1: begin
                            scl_drv = 1'b1;
                            arm(DLY_7, 4'd2);
                        end
                        4'd2: begin
                            shreg = {shreg[6:0], sda_in};
                            arm(DLY_3, 4'd3);
                        end
                        4'd3: begin
                            scl_drv = 1'b0;
                            if (bit_cnt >= 4'd7) begin
                                arm(DLY_10, 4'd4);
                            end else begin
                                bit_cnt = bit_cnt + 4'd1;
                                arm(DLY_10, 4'd1);
                            end
                        end
                        4'd4: begin
                            sda_drv = ~ack_bit;
                            arm(DLY_10, 4'd5);
                        end
                        4'd5: begin
                            scl_drv = 1'b1;
                            arm(DLY_50, 4'd6);
                        end
                        default: begin
                            scl_drv = 1'b0;
                            return 1'b1;
                        end
                    endcase
                end
                default: return 1'b1;
            endcase
            return 1'b0;
        endfunction

        // Advance one tick and queue the pin levels it should produce.
        function void note_tick(t_drv_tick t);
            t_levels    r;
            logic       was_busy;
            logic       fin;
            logic       expired;
            logic [2:0] fin_cmd;
            was_busy = busy();
            fin      = 1'b0;
            expired  = 1'b0;
            fin_cmd  = CMD_IDLE;
            if (was_busy) begin
                if (tick_left > 16'd1) begin
                    tick_left = tick_left - 16'd1;
                end else begin
                    tick_left = unit_ticks();
                    if (units_left > 6'd1) begin
                        units_left = units_left - 6'd1;
                    end else begin
                        units_left = '0;
                        expired    = 1'b1;
                    end
                end
                if (expired) fin = perform(t.sda_in);
            end else if (t.cmd_valid && t.req_type <= CMD_READ) begin
                cmd_now = t.req_type;
                step    = '0;
                bit_cnt = '0;
                if (t.req_type == CMD_WRITE) begin
                    shreg   = t.tx_byte;
                    ack_bit = 1'b0;
                end
                if (t.req_type == CMD_READ) begin
                    shreg   = '0;
                    ack_bit = t.send_ack;
                end
                fin = perform(t.sda_in);
            end
            if (fin) begin
                fin_cmd    = cmd_now;
                cmd_now    = CMD_IDLE;
                step       = '0;
                units_left = '0;
                tick_left  = '0;
            end
            r.scl      = scl_drv;
            r.sda      = sda_drv;
            r.busy     = busy();
            r.done     = fin;
            r.ack      = (fin && fin_cmd == CMD_WRITE) ? ack_bit : 1'b0;
            r.rx       = (fin && fin_cmd == CMD_READ) ? shreg : 8'h00;
            r.rejected = t.cmd_valid && was_busy;
            levels_due.push_back(r);
        endfunction

        // Compare one result beat with the oldest pending expectation.
        function void check_levels(t_levels got);
            t_levels exp;
            beats_seen++;
            if (levels_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("beat %0d: result with nothing expected", beats_seen);
                return;
            end
            exp = levels_due.pop_front();
            if (got !== exp) begin
                faults++;
                if (faults <= 10) begin
                    $display("beat %0d: exp scl %b sda %b busy %b done %b ack %b rx %02h rej %b",
                             beats_seen, exp.scl, exp.sda, exp.busy, exp.done, exp.ack,
                             exp.rx, exp.rejected);
                    $display("beat %0d: got scl %b sda %b busy %b done %b ack %b rx %02h rej %b",
                             beats_seen, got.scl, got.sda, got.busy, got.done, got.ack,
                             got.rx, got.rejected);
                end
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [15:0] i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic        i_cmd_valid    = 1'b0;
    logic [2:0]  i_req_type     = CMD_START;
    logic [7:0]  i_tx_byte      = '0;
    logic        i_send_ack     = 1'b0;
    logic        i_sda_in       = 1'b1;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic        o_scl_level;
    logic        o_sda_level;
    logic        o_busy_res;
    logic        o_done_res;
    logic        o_ack_received;
    logic [7:0]  o_rx_byte;
    logic        o_cmd_rejected;

    i2c_bus_tracker tracker;
    bit             quiet      = 1'b0;
    int             ticks_sent = 0;
    int             stall_cnt  = 0;

    i2c_master_bit_sequencer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd_valid    (i_cmd_valid),
        .i_req_type     (i_req_type),
        .i_tx_byte      (i_tx_byte),
        .i_send_ack     (i_send_ack),
        .i_sda_in       (i_sda_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_scl_level    (o_scl_level),
        .o_sda_level    (o_sda_level),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_ack_received (o_ack_received),
        .o_rx_byte      (o_rx_byte),
        .o_cmd_rejected (o_cmd_rejected)
    );

    // Free-running clock.
    always #4 i_clk = ~i_clk;

    // The result side stalls at random unless a quiet stretch is running.
    always @(posedge i_clk) begin
        if (quiet) i_out_ready <= 1'b1;
        else       i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Check every result beat taken from the block.
    always @(posedge i_clk) begin : take_result
        t_levels got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.scl      = o_scl_level;
            got.sda      = o_sda_level;
            got.busy     = o_busy_res;
            got.done     = o_done_res;
            got.ack      = o_ack_received;
            got.rx       = o_rx_byte;
            got.rejected = o_cmd_rejected;
            tracker.check_levels(got);
        end
    end

    // Give up when neither side has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX) begin
            $display("tb_i2c_master_bit_sequencer_core: done, errors");
            $finish;
        end
    end

    function automatic logic pick_sda(int mode);
        if (mode == SDA_LOW) return 1'b0;
        if (mode == SDA_HIGH) return 1'b1;
        return 1'($urandom_range(1));
    endfunction

    function automatic t_drv_tick rand_tick(logic cmd_valid, int sda_mode);
        t_drv_tick t;
        t.cmd_valid = cmd_valid;
        t.req_type  = 3'($urandom_range(7));
        t.tx_byte   = 8'($urandom_range(255));
        t.send_ack  = 1'($urandom_range(1));
        t.sda_in    = pick_sda(sda_mode);
        return t;
    endfunction

    // Offer one tick, with random gaps ahead of it, and hold it until taken.
    task automatic send_tick(input t_drv_tick t);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd_valid <= t.cmd_valid;
        i_req_type  <= t.req_type;
        i_tx_byte   <= t.tx_byte;
        i_send_ack  <= t.send_ack;
        i_sda_in    <= t.sda_in;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_tick(t);
        ticks_sent++;
    endtask

    // Issue a command and keep ticking until the sequence has finished.
    // Stray commands land while busy; poke_done also aims one at the closing tick.
    task automatic run_command(input logic [2:0] code, input logic [7:0] tx,
                               input logic ack, input int sda_mode,
                               input int reject_pct, input bit poke_done);
        t_drv_tick t;
        t.cmd_valid = 1'b1;
        t.req_type  = code;
        t.tx_byte   = tx;
        t.send_ack  = ack;
        t.sda_in    = pick_sda(sda_mode);
        send_tick(t);
        while (tracker.busy()) begin
            t = rand_tick(($urandom_range(99) < reject_pct) ||
                          (poke_done && tracker.finishing_next()), sda_mode);
            send_tick(t);
        end
    endtask

    // Let every expected beat arrive, then give the pipeline time to settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tpu(input logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        tracker.write_tpu(v);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly whole commands with random content, some idle and unknown ticks.
    task automatic random_phase(input int n_ticks);
        int first;
        int k;
        first = ticks_sent;
        while (ticks_sent - first < n_ticks) begin
            k = $urandom_range(99);
            if (k < 8) begin
                run_command(3'($urandom_range(7, 5)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), SDA_RAND, 0, 1'b0);
            end else if (k < 20) begin
                send_tick(rand_tick(1'b0, SDA_RAND));
            end else begin
                run_command(3'($urandom_range(4)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), SDA_RAND, 4, k < 40);
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unknown codes and an idle tick, then every command once or more.
        run_command(CMD_UNK_A, 8'h00, 1'b0, SDA_LOW, 0, 1'b0);
        run_command(CMD_UNK_B, 8'hFF, 1'b1, SDA_HIGH, 0, 1'b0);
        run_command(CMD_IDLE, 8'h5A, 1'b1, SDA_RAND, 0, 1'b0);
        send_tick(rand_tick(1'b0, SDA_HIGH));
        run_command(CMD_START, 8'h00, 1'b0, SDA_RAND, 0, 1'b1);
        run_command(CMD_RESTART, 8'hFF, 1'b1, SDA_RAND, 15, 1'b1);
        run_command(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 0, 1'b1);
        run_command(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 20, 1'b0);
        run_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 0, 1'b1);
        run_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 10, 1'b0);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 0, 1'b1);
        drain();

        // A zero unit length counts as one tick per unit.
        write_tpu(16'h0000);
        random_phase(120);
        drain();

        // One tick per unit with both sides streaming and no gaps.
        write_tpu(16'h0001);
        quiet = 1'b1;
        random_phase(120);
        drain();
        quiet = 1'b0;

        write_tpu(16'h0002);
        random_phase(80);
        drain();

        // Longest unit: the sequence only gets under way before the run ends.
        write_tpu(16'hFFFF);
        run_command(CMD_IDLE, 8'h00, 1'b0, SDA_RAND, 0, 1'b0);
        send_tick('{1'b1, CMD_START, 8'h00, 1'b0, 1'b1});
        repeat (150) send_tick(rand_tick($urandom_range(99) < 10, SDA_RAND));
        drain();

        if (tracker.faults == 0) begin
            $display("tb_i2c_master_bit_sequencer_core: done, clean");
        end else begin
            $display("tb_i2c_master_bit_sequencer_core: done, errors");
        end
        $finish;
    end

endmodule
